// ===== sv/pgrd_pkg.sv =====
// Package for the packed glyph raster decoder.
// Holds status codes, number phases, limits and the controller/datapath
// interface types. No dependencies.
`timescale 1ns / 1ps

package pgrd_pkg;

  // Glyph size limits
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 32;

  // Result status codes
  localparam logic [3:0] ST_ROW        = 4'd0;
  localparam logic [3:0] ST_DONE       = 4'd1;
  localparam logic [3:0] ST_TRUNC      = 4'd2;
  localparam logic [3:0] ST_LARGE      = 4'd3;
  localparam logic [3:0] ST_RANGE      = 4'd4;
  localparam logic [3:0] ST_REPEAT2    = 4'd5;
  localparam logic [3:0] ST_ZERO       = 4'd6;
  localparam logic [3:0] ST_REPH       = 4'd7;
  localparam logic [3:0] ST_OVERH      = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_DYN    = 2'd0;
  localparam logic [1:0] CFG_BLACK  = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  // Dynamic factor codes and nybble prefixes
  localparam logic [3:0] DYN_RAW    = 4'd14;
  localparam logic [3:0] DYN_BAD    = 4'd15;
  localparam logic [3:0] PFX_REPEAT = 4'd14;
  localparam logic [3:0] LONG_TOP   = 4'd13;
  localparam logic [31:0] LONG_BIAS = 32'd15;

  // Packed number phases (bit 2 marks a repeat count)
  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_SECOND = 3'd1;
  localparam logic [2:0] PH_ZEROS  = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_REPNUM = 3'd4;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LATCH, OP_CHECK, OP_NYB, OP_PAINT, OP_ROW, OP_RAW, OP_TAIL,
    OP_FIN, OP_FLUSH
  } dp_op_t;

  typedef enum logic [2:0] {
    OC_NEXT, OC_NYB, OC_DONE, OC_PAINT, OC_ROWS, OC_RAW, OC_FIN
  } outc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_NYB, S_PAINT, S_ROWS, S_RAW, S_TAIL, S_FIN, S_END
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    outc_t outc;
    logic  finished;
    logic  can_push;
    logic  pend_v;
    logic  out_free;
  } dp_stat_t;

endpackage

// ===== sv/pgrd_ctrl.sv =====
// Controller state machine of the packed glyph raster decoder.
// Depends on pgrd_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module pgrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              cfg_ready,
  input  pgrd_pkg::dp_stat_t stat,
  output pgrd_pkg::dp_cmd_t  cmd
);
  import pgrd_pkg::*;

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = stat.finished ? S_IDLE : S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = OP_CHECK;
        priority case (stat.outc)
          OC_FIN:  state_next = S_FIN;
          OC_RAW:  state_next = S_RAW;
          default: state_next = S_NYB;
        endcase
      end
      S_NYB: begin
        cmd.op = OP_NYB;
        priority case (stat.outc)
          OC_FIN:   state_next = S_FIN;
          OC_PAINT: state_next = S_PAINT;
          OC_DONE:  state_next = S_TAIL;
          default:  state_next = S_NYB;
        endcase
      end
      S_PAINT: begin
        cmd.op = OP_PAINT;
        priority case (stat.outc)
          OC_FIN:  state_next = S_FIN;
          OC_ROWS: state_next = S_ROWS;
          OC_DONE: state_next = S_TAIL;
          OC_NYB:  state_next = S_NYB;
          default: state_next = S_PAINT;
        endcase
      end
      S_ROWS: begin
        if (stat.can_push) begin
          cmd.op = OP_ROW;
          priority case (stat.outc)
            OC_FIN:   state_next = S_FIN;
            OC_PAINT: state_next = S_PAINT;
            OC_DONE:  state_next = S_TAIL;
            OC_NYB:   state_next = S_NYB;
            default:  state_next = S_ROWS;
          endcase
        end
      end
      S_RAW: begin
        if (stat.can_push) begin
          cmd.op = OP_RAW;
          priority case (stat.outc)
            OC_FIN:  state_next = S_FIN;
            OC_DONE: state_next = S_TAIL;
            default: state_next = S_RAW;
          endcase
        end
      end
      S_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = (stat.outc == OC_FIN) ? S_FIN : S_END;
      end
      S_FIN: begin
        if (stat.can_push) begin
          cmd.op     = OP_FIN;
          state_next = S_END;
        end
      end
      S_END: begin
        // Release the held word marked as last of this byte
        if (!stat.pend_v) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.op     = OP_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/pgrd_datapath.sv =====
// Datapath of the packed glyph raster decoder: configuration, number
// decoding, run painting, raw unpacking and the output word registers.
// Depends on pgrd_pkg; driven by pgrd_ctrl.
`timescale 1ns / 1ps

module pgrd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic [7:0]         raster_byte,
  input  logic               last_byte,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [3:0]         status,
  output logic [5:0]         row_index,
  output logic [63:0]        row_bits,
  output logic               last,
  input  pgrd_pkg::dp_cmd_t  cmd,
  output pgrd_pkg::dp_stat_t stat
);
  import pgrd_pkg::*;

  // Configuration
  logic [3:0]  dyn_factor;
  logic        first_black;
  logic [6:0]  glyph_width;
  logic [5:0]  glyph_height;

  // Decode state
  logic [7:0]  byte_r, byte_r_next;
  logic        lastb_r, lastb_r_next;
  logic        lo_half, lo_half_next;
  logic [63:0] row_store, row_store_next;
  logic [6:0]  column_pos, column_pos_next;
  logic [5:0]  current_row, current_row_next;
  logic        paint_black, paint_black_next;
  logic [31:0] repeat_count, repeat_count_next;
  logic [2:0]  number_phase, number_phase_next;
  logic [5:0]  zero_count, zero_count_next;
  logic [31:0] number_accum, number_accum_next;
  logic [3:0]  first_nybble, first_nybble_next;
  logic [31:0] remaining, remaining_next;
  logic [5:0]  row_ptr, row_ptr_next;
  logic [2:0]  raw_idx, raw_idx_next;
  logic [3:0]  fin_code, fin_code_next;
  logic        finished, finished_next;

  // Output words
  logic        pend_v;
  logic [3:0]  pend_status;
  logic [5:0]  pend_row;
  logic [63:0] pend_bits;

  logic        push_en;
  logic [3:0]  push_status;
  logic [5:0]  push_row;
  logic [63:0] push_bits;
  outc_t       outc;
  logic        out_free, can_push;

  // Temporaries
  logic [3:0]  nyb;
  logic        rep;
  outc_t       oc_cont;
  logic        num_ready;
  logic [31:0] num_val;
  logic [8:0]  two_val;
  logic [35:0] wide;
  logic [5:0]  zc_dec;
  logic [7:0]  long_base;
  logic [32:0] long_sum;
  logic [6:0]  avail, taken, col_new;
  logic [31:0] rem_new;
  logic [63:0] run_mask;
  logic [5:0]  last_row, cur_new;
  logic [63:0] raw_rs;

  assign out_free = !out_valid || !out_stall;
  assign can_push = !pend_v || out_free;

  assign stat.outc     = outc;
  assign stat.finished = finished;
  assign stat.can_push = can_push;
  assign stat.pend_v   = pend_v;
  assign stat.out_free = out_free;

  // Step logic for the current command
  always_comb begin
    byte_r_next       = byte_r;
    lastb_r_next      = lastb_r;
    lo_half_next      = lo_half;
    row_store_next    = row_store;
    column_pos_next   = column_pos;
    current_row_next  = current_row;
    paint_black_next  = paint_black;
    repeat_count_next = repeat_count;
    number_phase_next = number_phase;
    zero_count_next   = zero_count;
    number_accum_next = number_accum;
    first_nybble_next = first_nybble;
    remaining_next    = remaining;
    row_ptr_next      = row_ptr;
    raw_idx_next      = raw_idx;
    fin_code_next     = fin_code;
    finished_next     = finished;
    outc              = OC_NEXT;
    push_en           = 1'b0;
    push_status       = ST_ROW;
    push_row          = row_ptr;
    push_bits         = row_store;

    nyb       = lo_half ? byte_r[3:0] : byte_r[7:4];
    rep       = number_phase[2];
    oc_cont   = lo_half ? OC_DONE : OC_NYB;
    num_ready = 1'b0;
    num_val   = 32'd0;
    two_val   = {1'b0, first_nybble - dyn_factor - 4'd1, nyb} + {5'd0, dyn_factor} + 9'd1;
    wide      = {number_accum, nyb};
    zc_dec    = zero_count - 6'd1;
    long_base = {LONG_TOP - dyn_factor, 4'd0} + {4'd0, dyn_factor};
    long_sum  = {1'b0, wide[31:0]} - {1'b0, LONG_BIAS} + {25'd0, long_base};
    avail     = glyph_width - column_pos;
    taken     = (remaining < {25'd0, avail}) ? remaining[6:0] : avail;
    col_new   = column_pos + taken;
    rem_new   = remaining - {25'd0, taken};
    run_mask  = ({64{1'b1}} >> column_pos) & ~({64{1'b1}} >> col_new);
    last_row  = current_row + repeat_count[5:0];
    cur_new   = row_ptr + 6'd1;
    raw_rs    = row_store | (byte_r[raw_idx] ? (64'h8000_0000_0000_0000 >> column_pos)
                                             : 64'd0);

    unique case (cmd.op)
      OP_LATCH: begin
        byte_r_next  = raster_byte;
        lastb_r_next = last_byte;
        lo_half_next = 1'b0;
        raw_idx_next = 3'd7;
      end
      OP_CHECK: begin
        if (dyn_factor == DYN_BAD) begin
          fin_code_next = ST_RANGE;
          outc          = OC_FIN;
        end else if (glyph_width == 7'd0 || glyph_height == 6'd0) begin
          fin_code_next = ST_DONE;
          outc          = OC_FIN;
        end else if (glyph_width > 7'(MAX_WIDTH) || glyph_height > 6'(MAX_HEIGHT)) begin
          fin_code_next = ST_LARGE;
          outc          = OC_FIN;
        end else if (dyn_factor == DYN_RAW) begin
          outc = OC_RAW;
        end else begin
          outc = OC_NYB;
        end
      end
      OP_NYB: begin
        outc         = oc_cont;
        lo_half_next = 1'b1;
        unique case (number_phase[1:0])
          PH_FIRST[1:0]: begin
            if (nyb == 4'd0) begin
              zero_count_next   = 6'd0;
              number_phase_next = {rep, PH_ZEROS[1:0]};
            end else if (nyb <= dyn_factor) begin
              num_ready = 1'b1;
              num_val   = {28'd0, nyb};
            end else if (nyb < PFX_REPEAT) begin
              first_nybble_next = nyb;
              number_phase_next = {rep, PH_SECOND[1:0]};
            end else if (rep || repeat_count != 32'd0) begin
              fin_code_next = ST_REPEAT2;
              outc          = OC_FIN;
            end else if (nyb == PFX_REPEAT) begin
              number_phase_next = PH_REPNUM;
            end else begin
              repeat_count_next = 32'd1;
              number_phase_next = PH_FIRST;
            end
          end
          PH_SECOND[1:0]: begin
            num_ready = 1'b1;
            num_val   = {23'd0, two_val};
          end
          PH_ZEROS[1:0]: begin
            if (zero_count != 6'd63) begin
              zero_count_next = zero_count + 6'd1;
            end
            if (nyb != 4'd0) begin
              number_accum_next = {28'd0, nyb};
              number_phase_next = {rep, PH_DIGITS[1:0]};
            end
          end
          default: begin
            // Long number digits
            if (wide[35:32] != 4'd0) begin
              fin_code_next = ST_LARGE;
              outc          = OC_FIN;
            end else begin
              number_accum_next = wide[31:0];
              zero_count_next   = zc_dec;
              if (zc_dec == 6'd0) begin
                if (wide[31:0] < LONG_BIAS || long_sum[32]) begin
                  fin_code_next = ST_RANGE;
                  outc          = OC_FIN;
                end else begin
                  num_ready = 1'b1;
                  num_val   = long_sum[31:0];
                end
              end
            end
          end
        endcase
        // Finished number: repeat count, a run to paint, or a zero run that ends the glyph
        if (num_ready) begin
          number_phase_next = PH_FIRST;
          if (rep) begin
            repeat_count_next = num_val;
          end else if (num_val == 32'd0) begin
            fin_code_next = ST_ZERO;
            outc          = OC_FIN;
          end else begin
            remaining_next = num_val;
            lo_half_next   = lo_half;
            outc           = OC_PAINT;
          end
        end
      end
      OP_PAINT: begin
        if (paint_black) begin
          row_store_next = row_store | run_mask;
        end
        column_pos_next = col_new;
        remaining_next  = rem_new;
        if (col_new == glyph_width) begin
          if (repeat_count > {26'd0, glyph_height - current_row - 6'd1}) begin
            fin_code_next = ST_REPH;
            outc          = OC_FIN;
          end else begin
            row_ptr_next = current_row;
            outc         = OC_ROWS;
          end
        end else begin
          paint_black_next = !paint_black;
          lo_half_next     = 1'b1;
          outc             = oc_cont;
        end
      end
      OP_ROW: begin
        push_en = 1'b1;
        if (row_ptr != last_row) begin
          row_ptr_next = cur_new;
          outc         = OC_ROWS;
        end else begin
          current_row_next  = cur_new;
          column_pos_next   = 7'd0;
          repeat_count_next = 32'd0;
          row_store_next    = 64'd0;
          if (cur_new == glyph_height) begin
            fin_code_next = (remaining != 32'd0) ? ST_OVERH : ST_DONE;
            outc          = OC_FIN;
          end else if (remaining != 32'd0) begin
            outc = OC_PAINT;
          end else begin
            paint_black_next = !paint_black;
            lo_half_next     = 1'b1;
            outc             = oc_cont;
          end
        end
      end
      OP_RAW: begin
        outc = (raw_idx == 3'd0) ? OC_DONE : OC_NEXT;
        raw_idx_next = raw_idx - 3'd1;
        if (column_pos + 7'd1 == glyph_width) begin
          push_en          = 1'b1;
          push_row         = current_row;
          push_bits        = raw_rs;
          current_row_next = current_row + 6'd1;
          column_pos_next  = 7'd0;
          row_store_next   = 64'd0;
          if (current_row + 6'd1 == glyph_height) begin
            fin_code_next = ST_DONE;
            outc          = OC_FIN;
          end
        end else begin
          column_pos_next = column_pos + 7'd1;
          row_store_next  = raw_rs;
        end
      end
      OP_TAIL: begin
        if (lastb_r && !finished) begin
          fin_code_next = ST_TRUNC;
          outc          = OC_FIN;
        end else begin
          outc = OC_DONE;
        end
      end
      OP_FIN: begin
        push_en       = 1'b1;
        push_status   = fin_code;
        push_row      = 6'd0;
        push_bits     = 64'd0;
        finished_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration and decode state; a register write restarts the glyph
  always_ff @(posedge clk) begin
    if (rst) begin
      dyn_factor   <= 4'd0;
      first_black  <= 1'b0;
      glyph_width  <= 7'd0;
      glyph_height <= 6'd0;
      row_store    <= 64'd0;
      column_pos   <= 7'd0;
      current_row  <= 6'd0;
      paint_black  <= 1'b0;
      repeat_count <= 32'd0;
      number_phase <= PH_FIRST;
      zero_count   <= 6'd0;
      number_accum <= 32'd0;
      first_nybble <= 4'd0;
      finished     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DYN:    dyn_factor   <= cfg_data[3:0];
        CFG_BLACK:  first_black  <= cfg_data[0];
        CFG_WIDTH:  glyph_width  <= cfg_data;
        CFG_HEIGHT: glyph_height <= cfg_data[5:0];
        default: begin
        end
      endcase
      row_store    <= 64'd0;
      column_pos   <= 7'd0;
      current_row  <= 6'd0;
      paint_black  <= (cfg_index == CFG_BLACK) ? cfg_data[0] : first_black;
      repeat_count <= 32'd0;
      number_phase <= PH_FIRST;
      zero_count   <= 6'd0;
      number_accum <= 32'd0;
      first_nybble <= 4'd0;
      finished     <= 1'b0;
    end else begin
      row_store    <= row_store_next;
      column_pos   <= column_pos_next;
      current_row  <= current_row_next;
      paint_black  <= paint_black_next;
      repeat_count <= repeat_count_next;
      number_phase <= number_phase_next;
      zero_count   <= zero_count_next;
      number_accum <= number_accum_next;
      first_nybble <= first_nybble_next;
      finished     <= finished_next;
    end
  end

  // Per-byte working registers
  always_ff @(posedge clk) begin
    byte_r    <= byte_r_next;
    lastb_r   <= lastb_r_next;
    lo_half   <= lo_half_next;
    remaining <= remaining_next;
    row_ptr   <= row_ptr_next;
    raw_idx   <= raw_idx_next;
    fin_code  <= fin_code_next;
  end

  // Held word and output word: the held word goes out marked last only
  // once the byte is fully decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push_en && pend_v) begin
        out_valid <= 1'b1;
        status    <= pend_status;
        row_index <= pend_row;
        row_bits  <= pend_bits;
        last      <= 1'b0;
      end else if (cmd.op == OP_FLUSH) begin
        out_valid <= 1'b1;
        status    <= pend_status;
        row_index <= pend_row;
        row_bits  <= pend_bits;
        last      <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        pend_v      <= 1'b1;
        pend_status <= push_status;
        pend_row    <= push_row;
        pend_bits   <= push_bits;
      end else if (cmd.op == OP_FLUSH) begin
        pend_v <= 1'b0;
      end
    end
  end

  // A word is only produced when there is room for it
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_en |-> can_push) else $error("word pushed without room");

  // A status word ends the glyph
  a_fin_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FIN && !cfg_we) |=> finished) else $error("finish lost");

  // The column never passes the row width limit
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column_pos <= 7'(MAX_WIDTH)) else $error("column out of range");

  // Flushing only releases a held word into a free output register
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FLUSH) |-> (pend_v && out_free)) else $error("bad flush");

endmodule

// ===== sv/packed_glyph_raster_decoder.sv =====
// Top level of the packed glyph raster decoder.
// Depends on pgrd_pkg, pgrd_ctrl and pgrd_datapath.
`timescale 1ns / 1ps

// Usage:
// Software writes dyn_factor, first_black, glyph_width and glyph_height on
// the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) before each
// glyph; any write restarts the glyph. Raster bytes then enter on the input
// channel (in_valid/in_stall), high nybble first; last_byte marks the final
// byte. Each byte yields zero or more result words on the output channel
// (out_valid/out_stall): rows, repeated row copies, and one closing status
// word; the last word of a byte carries last.
// Flow: one byte at a time. A run-mode byte steps through accept, check, two
// nybble steps, tail and release, plus one paint step per row segment a run
// touches and one step per emitted row; a raw byte steps through accept,
// check, eight one-bit unpack steps, tail and release. Each result word passes
// through the two-entry output stage.
// Reset clears the configuration and glyph state to zero, empties the output
// stage and returns the controller to idle. When the receiver stalls, the
// output stage fills and the controller holds; the input stays stalled until
// the current byte's last word has moved into the output register.
module packed_glyph_raster_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  raster_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [5:0]  row_index,
  output logic [63:0] row_bits,
  output logic        last
);
  import pgrd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pgrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pgrd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .raster_byte (raster_byte),
    .last_byte   (last_byte),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .row_index   (row_index),
    .row_bits    (row_bits),
    .last        (last),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ===== sim/tb_packed_glyph_raster_decoder.sv =====
// Testbench for the packed glyph raster decoder: directed stimulus table, then
// random glyphs in run, raw and invalid-factor mode, checked word by word against a glyph model.
// Depends on pgrd_pkg and packed_glyph_raster_decoder.
`timescale 1ns / 1ps

module tb_packed_glyph_raster_decoder;
  import pgrd_pkg::*;

  localparam logic [3:0] RPT_ONCE = 4'd15;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 165;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  row;
    logic [63:0] bits;
    logic        last;
  } word_t;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] idx;
    logic [7:0] val;
    logic       lastb;
    logic       typed;
    logic [3:0] want;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  raster_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  status;
  logic [5:0]  row_index;
  logic [63:0] row_bits;
  logic        last;

  packed_glyph_raster_decoder DUT (.*);

  always #5 clk = ~clk;

  // Glyph model state
  logic [3:0]  g_dyn;
  logic        g_black;
  logic [6:0]  g_width;
  logic [5:0]  g_height;
  logic [63:0] g_row;
  int unsigned g_col, g_cur, g_rep, g_acc;
  logic [3:0]  g_first;
  logic [2:0]  g_phase;
  logic [5:0]  g_zeros;
  logic        g_paint, g_done;
  int          words_this_byte;
  logic [3:0]  step_status;

  word_t expected_words[$];
  bit    failed = 1'b0;
  int    send_idle = 0;
  int    recv_idle = 0;
  bit    long_hold_req = 1'b0;
  logic [3:0] run_nybbles[$];

  function automatic void emit_word(logic [3:0] st, int unsigned r, logic [63:0] bits);
    word_t w;
    if (words_this_byte < 64) begin
      w.status = st;
      w.row = r[5:0];
      w.bits = bits;
      w.last = 1'b0;
      expected_words.push_back(w);
      words_this_byte++;
    end
  endfunction

  function automatic void end_glyph(logic [3:0] st);
    emit_word(st, 0, '0);
    g_done = 1'b1;
  endfunction

  function automatic void restart_glyph();
    g_row = '0;
    g_col = 0;
    g_cur = 0;
    g_paint = g_black;
    g_rep = 0;
    g_phase = PH_FIRST;
    g_zeros = '0;
    g_acc = 0;
    g_first = '0;
    g_done = 1'b0;
  endfunction

  function automatic void model_config(logic [1:0] idx, logic [6:0] data);
    case (idx)
      CFG_DYN: g_dyn = data[3:0];
      CFG_BLACK: g_black = data[0];
      CFG_WIDTH: g_width = data;
      default: g_height = data[5:0];
    endcase
    restart_glyph();
  endfunction

  // Paint one run across rows, emitting finished rows and their copies
  function automatic void paint_run(int unsigned run, int unsigned w, int unsigned h);
    longint unsigned remaining;
    int unsigned avail, taken;
    logic [63:0] ones;
    remaining = run;
    while (remaining != 0) begin
      avail = w - g_col;
      taken = (remaining < avail) ? 32'(remaining) : avail;
      if (g_paint && taken != 0) begin
        ones = (taken >= 64) ? '1 : ((64'd1 << taken) - 64'd1);
        g_row |= ones << (64 - g_col - taken);
      end
      g_col += taken;
      remaining -= taken;
      if (g_col == w) begin
        if (g_rep > h - g_cur - 1) begin
          end_glyph(ST_REPH);
          return;
        end
        for (int unsigned k = 0; k <= g_rep; k++) emit_word(ST_ROW, g_cur + k, g_row);
        g_cur += g_rep + 1;
        g_col = 0;
        g_rep = 0;
        g_row = '0;
        if (g_cur == h) begin
          end_glyph(remaining != 0 ? ST_OVERH : ST_DONE);
          return;
        end
      end
    end
    g_paint = ~g_paint;
  endfunction

  function automatic void number_ready(int unsigned v, int unsigned w, int unsigned h);
    logic rep;
    rep = g_phase[2];
    g_phase = PH_FIRST;
    if (rep) begin
      g_rep = v;
      return;
    end
    if (v == 0) begin
      end_glyph(ST_ZERO);
      return;
    end
    paint_run(v, w, h);
  endfunction

  function automatic void take_nybble(logic [3:0] d, int unsigned w, int unsigned h);
    logic [2:0] sub, rep;
    longint unsigned acc, base;
    int unsigned dyn;
    dyn = g_dyn;
    sub = g_phase & 3'd3;
    rep = g_phase & PH_REPNUM;
    if (sub == PH_FIRST) begin
      if (d == 0) begin
        g_zeros = '0;
        g_phase = rep | PH_ZEROS;
      end else if (d <= dyn) begin
        number_ready(d, w, h);
      end else if (d < PFX_REPEAT) begin
        g_first = d;
        g_phase = rep | PH_SECOND;
      end else if (rep != 0 || g_rep != 0) begin
        end_glyph(ST_REPEAT2);
      end else if (d == PFX_REPEAT) begin
        g_phase = PH_REPNUM | PH_FIRST;
      end else begin
        g_rep = 1;
        g_phase = PH_FIRST;
      end
    end else if (sub == PH_SECOND) begin
      number_ready((g_first - dyn - 1) * 16 + d + dyn + 1, w, h);
    end else if (sub == PH_ZEROS) begin
      if (g_zeros < 6'd63) g_zeros++;
      if (d != 0) begin
        g_acc = d;
        g_phase = rep | PH_DIGITS;
      end
    end else begin
      acc = g_acc;
      if (acc > (64'hFFFF_FFFF - d) / 16) begin
        end_glyph(ST_LARGE);
        return;
      end
      acc = acc * 16 + d;
      g_acc = acc[31:0];
      g_zeros--;
      if (g_zeros != 0) return;
      base = (LONG_TOP - dyn) * 16 + dyn;
      if (acc < LONG_BIAS || acc - LONG_BIAS + base > 64'hFFFF_FFFF) begin
        end_glyph(ST_RANGE);
        return;
      end
      number_ready(32'(acc - LONG_BIAS + base), w, h);
    end
  endfunction

  // Predict the words that one accepted byte produces
  function automatic void glyph_step(logic [7:0] rb, logic lb);
    int unsigned w, h;
    word_t tail;
    words_this_byte = 0;
    if (g_done) return;
    w = g_width;
    h = g_height;
    if (g_dyn == DYN_BAD) begin
      end_glyph(ST_RANGE);
    end else if (w == 0 || h == 0) begin
      end_glyph(ST_DONE);
    end else if (w > MAX_WIDTH || h > MAX_HEIGHT) begin
      end_glyph(ST_LARGE);
    end else if (g_dyn == DYN_RAW) begin
      for (int i = 7; i >= 0 && !g_done; i--) begin
        if (rb[i]) g_row |= 64'h8000_0000_0000_0000 >> g_col;
        g_col++;
        if (g_col == w) begin
          emit_word(ST_ROW, g_cur, g_row);
          g_cur++;
          g_col = 0;
          g_row = '0;
          if (g_cur == h) end_glyph(ST_DONE);
        end
      end
    end else begin
      take_nybble(rb[7:4], w, h);
      if (!g_done) take_nybble(rb[3:0], w, h);
    end
    if (!g_done && lb) end_glyph(ST_TRUNC);
    if (words_this_byte > 0) begin
      tail = expected_words.pop_back();
      tail.last = 1'b1;
      step_status = tail.status;
      expected_words.push_back(tail);
    end
  endfunction

  // Hold until every expected word has come and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_glyph(logic [3:0] dyn, logic blk, logic [6:0] w, logic [5:0] h);
    cfg_write(CFG_DYN, {3'd0, dyn});
    cfg_write(CFG_BLACK, {6'd0, blk});
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, {1'b0, h});
  endtask

  // Offer one byte; on return it has been accepted and valid stays high
  task automatic push_byte(logic [7:0] rb, logic lb);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raster_byte <= rb;
    last_byte <= lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    glyph_step(rb, lb);
    @(negedge clk);
  endtask

  // Encode one run length as a packed number for the current dynamic factor
  task automatic queue_number(int unsigned v);
    int unsigned dyn, base, t, ndig;
    longint unsigned acc;
    dyn = g_dyn;
    base = (LONG_TOP - dyn) * 16 + dyn;
    if (v <= dyn) begin
      run_nybbles.push_back(v[3:0]);
    end else if (v <= base) begin
      t = v - dyn - 1;
      run_nybbles.push_back(4'(t / 16 + dyn + 1));
      run_nybbles.push_back(4'(t % 16));
    end else begin
      acc = v - base + LONG_BIAS;
      ndig = 0;
      for (longint unsigned a = acc; a != 0; a = a >> 4) ndig++;
      repeat (ndig - 1) run_nybbles.push_back(4'd0);
      for (int i = ndig - 1; i >= 0; i--) run_nybbles.push_back(acc[i*4 +: 4]);
    end
  endtask

  // Receiver: random stall, plus one long hold-off on request
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: status %0d row %0d bits %h", status, row_index, row_bits);
        failed = 1'b1;
      end else begin
        w = expected_words.pop_front();
        if (status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status);
          failed = 1'b1;
        end
        if (row_index !== w.row) begin
          $error("row_index: expected %0d, got %0d", w.row, row_index);
          failed = 1'b1;
        end
        if (row_bits !== w.bits) begin
          $error("row_bits: expected %h, got %h", w.bits, row_bits);
          failed = 1'b1;
        end
        if (last !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, last);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Directed rows: configuration writes and bytes, some with the status typed in
  stim_t directed[] = '{
    '{1'b0, CFG_DYN, 8'h00, 1'b0, 1'b1, ST_DONE},
    '{1'b1, CFG_DYN, 8'd15, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'hFF, 1'b1, 1'b1, ST_RANGE},
    '{1'b1, CFG_DYN, 8'd0, 1'b0, 1'b0, ST_ROW},
    '{1'b1, CFG_HEIGHT, 8'd1, 1'b0, 1'b0, ST_ROW},
    '{1'b1, CFG_WIDTH, 8'd65, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'h11, 1'b0, 1'b1, ST_LARGE},
    '{1'b1, CFG_WIDTH, 8'd64, 1'b0, 1'b0, ST_ROW},
    '{1'b1, CFG_HEIGHT, 8'd33, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'h11, 1'b0, 1'b1, ST_LARGE},
    '{1'b1, CFG_HEIGHT, 8'd32, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'hFF, 1'b0, 1'b1, ST_REPEAT2},
    '{1'b1, CFG_BLACK, 8'd1, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'h11, 1'b1, 1'b0, ST_ROW},
    '{1'b1, CFG_DYN, 8'd14, 1'b0, 1'b0, ST_ROW},
    '{1'b1, CFG_WIDTH, 8'd8, 1'b0, 1'b0, ST_ROW},
    '{1'b1, CFG_HEIGHT, 8'd1, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'hA5, 1'b0, 1'b0, ST_ROW},
    '{1'b1, CFG_DYN, 8'd13, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'hF8, 1'b0, 1'b1, ST_REPH},
    '{1'b1, CFG_DYN, 8'd0, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'h00, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'h00, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'h0F, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'hFF, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'hFF, 1'b0, 1'b0, ST_ROW},
    '{1'b0, CFG_DYN, 8'hFF, 1'b0, 1'b1, ST_OVERH},
    '{1'b0, CFG_DYN, 8'hF0, 1'b0, 1'b0, ST_ROW}
  };

  initial begin
    int items, gbytes, v;
    logic [3:0] dyn;
    logic [6:0] w;
    logic [5:0] h;
    logic [7:0] rb;
    logic [3:0] hi_nyb, lo_nyb;
    logic lb;

    g_dyn = '0;
    g_black = 1'b0;
    g_width = '0;
    g_height = '0;
    restart_glyph();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        cfg_write(directed[i].idx, directed[i].val[6:0]);
      end else begin
        push_byte(directed[i].val, directed[i].lastb);
        if (directed[i].typed &&
            (words_this_byte == 0 || step_status != directed[i].want)) begin
          $error("status: expected %0d, predicted %0d", directed[i].want, step_status);
          failed = 1'b1;
        end
      end
    end
    drain();

    // Random glyphs
    long_hold_req = 1'b1;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (items < 55) begin
        send_idle = 14;
        recv_idle = 54;
      end else if (items < 110) begin
        send_idle = 54;
        recv_idle = 14;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      v = $urandom_range(99);
      dyn = (v < 15) ? DYN_RAW : (v < 18) ? DYN_BAD : 4'($urandom_range(13));
      v = $urandom_range(99);
      w = (v < 4) ? 7'd0 : (v < 7) ? 7'(65 + $urandom_range(62)) :
          (v < 15) ? 7'd64 : 7'($urandom_range(16, 1));
      v = $urandom_range(99);
      h = (v < 3) ? 6'd0 : (v < 6) ? 6'(33 + $urandom_range(30)) :
          (v < 10) ? 6'd32 : 6'($urandom_range(5, 1));
      setup_glyph(dyn, 1'($urandom_range(1)), w, h);
      run_nybbles.delete();
      gbytes = 0;
      while (!g_done && gbytes < 48) begin
        if (dyn == DYN_RAW || dyn == DYN_BAD) begin
          rb = 8'($urandom_range(255));
        end else begin
          while (run_nybbles.size() < 2) begin
            v = $urandom_range(99);
            if (v < 4) begin
              run_nybbles.push_back(4'($urandom_range(15)));
            end else if (v < 9) begin
              run_nybbles.push_back(RPT_ONCE);
            end else if (v < 14) begin
              run_nybbles.push_back(PFX_REPEAT);
              queue_number($urandom_range(3));
            end else if (v < 22) begin
              queue_number($urandom_range(400, 1));
            end else begin
              queue_number($urandom_range(w > 0 && w <= 64 ? w : 8, 1));
            end
          end
          hi_nyb = run_nybbles.pop_front();
          lo_nyb = run_nybbles.pop_front();
          rb = {hi_nyb, lo_nyb};
        end
        lb = ($urandom_range(99) < 3) || gbytes == 47;
        push_byte(rb, lb);
        gbytes++;
        items++;
        if (items == 100) drain();
      end
      // an ignored byte after the glyph has closed
      if ($urandom_range(3) == 0) begin
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        items++;
      end
    end

    drain();
    if (!failed && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pgrd_pkg.sv
sv/pgrd_ctrl.sv
sv/pgrd_datapath.sv
sv/packed_glyph_raster_decoder.sv
sim/tb_packed_glyph_raster_decoder.sv
